// File: src/block_buffer_cache_tags_core_macros.svh
// ----------------------------------------------------------------------------
// Block buffer cache tags: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_TAGS_CORE_MACROS_SVH
`define BLOCK_BUFFER_CACHE_TAGS_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BBCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define BBCT_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bbct_pkg.sv
// ----------------------------------------------------------------------------
// Block buffer cache tags: package
// Request kinds, result actions, sequencer states and defaults.
// ----------------------------------------------------------------------------
package bbct_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_BLOCK_BITS = 24;
    localparam int REQ_W          = 3;
    localparam int ACT_W          = 2;
    localparam int SLOT_OUT_W     = 4;
    localparam int BLK_IN_W       = 24;

    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DWRITE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WTHRU  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PROBE  = 3'd4;

    localparam logic [ACT_W-1:0] ACT_GRANT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILL  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DONE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CMP,
        ST_PROBE,
        ST_VIC_EMIT,
        ST_RETAG,
        ST_GRANT,
        ST_FILL,
        ST_WTHRU,
        ST_FL_CHK,
        ST_FL_EMIT,
        ST_FL_DONE
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } ram_cmd_t;

endpackage

// File: src/bbct_tag_ram.sv
// ----------------------------------------------------------------------------
// Block buffer cache tags: tag memory
// One tag per slot, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bbct_tag_ram #(
    parameter int NUM_SLOTS  = bbct_pkg::DEF_NUM_SLOTS,
    parameter int BLOCK_BITS = bbct_pkg::DEF_BLOCK_BITS
) (
    input  logic                         clk,
    input  bbct_pkg::ram_cmd_t           cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0] addr,
    input  logic [BLOCK_BITS-1:0]        wdata,
    output logic [BLOCK_BITS-1:0]        rdata
);
    import bbct_pkg::*;

    logic [BLOCK_BITS-1:0] mem [NUM_SLOTS];
    logic [BLOCK_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/block_buffer_cache_tags_core.sv
// ----------------------------------------------------------------------------
// Block buffer cache tags: top level
// Tag lookup, victim choice and flush sequencing for a disk block cache.
// ----------------------------------------------------------------------------
// Channel  Dir  tvalid/tready  tdata                      tuser           tlast
// s_axis   in   request        req_block                  req_type        -
// m_axis   out  result         slot, disk_block           action, hit     last
//
// One request at a time: the idle state accepts it; a lookup then walks the queue
// with a tag read and a compare per position, and on a miss other than a probe
// writes back a dirty victim and retags it, then emits its results; a flush checks
// each position, emits each write-back and ends with a completion result.
// Reset (rst_n low, asynchronous) clears all marks and loads the queue.
// A stalled result holds in the output register; the sequencer waits in any state that must emit a result.
// ----------------------------------------------------------------------------
module block_buffer_cache_tags_core #(
    parameter int NUM_SLOTS  = bbct_pkg::DEF_NUM_SLOTS,
    parameter int BLOCK_BITS = bbct_pkg::DEF_BLOCK_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] req_block
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] slot, [27:4] disk_block, rest 0
    output logic [2:0]  m_axis_tuser,   // [1:0] action, [2] hit
    output logic        m_axis_tlast
);
    import bbct_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // sequencer state
    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      kind_reg, kind_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [SW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic                  hit_reg, hit_next;

    // per-slot marks and replacement queue (head at index 0)
    logic [NUM_SLOTS-1:0]  valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]  done_reg, done_next;
    logic [NUM_SLOTS-1:0]  dly_reg, dly_next;
    logic [SW-1:0]         queue_reg [NUM_SLOTS];
    logic [SW-1:0]         queue_next [NUM_SLOTS];

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]      out_act_reg, out_act_next;
    logic [SW-1:0]         out_slot_reg, out_slot_next;
    logic [BLOCK_BITS-1:0] out_blk_reg, out_blk_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_last_reg, out_last_next;

    // tag memory port
    ram_cmd_t              ram_cmd;
    logic [SW-1:0]         ram_addr;
    logic [BLOCK_BITS-1:0] ram_rdata;

    logic                  emit_ok;
    logic                  mtt;
    logic [SW-1:0]         mtt_pos;
    logic                  tag_match;

    bbct_tag_ram #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_tag_ram (
        .clk   (clk),
        .cmd   (ram_cmd),
        .addr  (ram_addr),
        .wdata (blk_reg),
        .rdata (ram_rdata)
    );

    assign emit_ok   = !out_valid_reg || m_axis_tready;
    assign tag_match = valid_reg[slot_reg] && (ram_rdata == blk_reg);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        valid_next     = valid_reg;
        done_next      = done_reg;
        dly_next       = dly_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_act_next   = out_act_reg;
        out_slot_next  = out_slot_reg;
        out_blk_next   = out_blk_reg;
        out_hit_next   = out_hit_reg;
        out_last_next  = out_last_reg;
        ram_cmd        = '0;
        ram_addr       = slot_reg;
        mtt            = 1'b0;
        mtt_pos        = pos_reg;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    kind_next = s_axis_tuser;
                    blk_next  = BLOCK_BITS'(s_axis_tdata);
                    pos_next  = '0;
                    cnt_next  = '0;
                    if (s_axis_tuser == REQ_FLUSH)
                    begin
                        state_next = ST_FL_CHK;
                    end
                    else if (s_axis_tuser inside {REQ_READ, REQ_DWRITE, REQ_WTHRU,
                                                  REQ_PROBE})
                    begin
                        state_next = ST_LK_RD;
                    end
                end
            end

            ST_LK_RD:
            begin
                // fetch the tag of the slot at this queue position
                ram_cmd.rd = 1'b1;
                ram_addr   = queue_reg[pos_reg];
                slot_next  = queue_reg[pos_reg];
                state_next = ST_LK_CMP;
            end

            ST_LK_CMP:
            begin
                if (tag_match)
                begin
                    hit_next   = 1'b1;
                    state_next = (kind_reg == REQ_PROBE) ? ST_PROBE : ST_GRANT;
                end
                else if (pos_reg != SW'(NUM_SLOTS - 1))
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_LK_RD;
                end
                else
                begin
                    hit_next = 1'b0;
                    if (kind_reg == REQ_PROBE)
                    begin
                        slot_next  = '0;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        // take the head slot; fetch its old tag if it is dirty
                        slot_next = queue_reg[0];
                        if (dly_reg[queue_reg[0]])
                        begin
                            ram_cmd.rd = 1'b1;
                            ram_addr   = queue_reg[0];
                            state_next = ST_VIC_EMIT;
                        end
                        else
                        begin
                            state_next = ST_RETAG;
                        end
                    end
                end
            end

            ST_PROBE:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_GRANT;
                    out_slot_next  = slot_reg;
                    out_blk_next   = blk_reg;
                    out_hit_next   = hit_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_VIC_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_WRITE;
                    out_slot_next  = slot_reg;
                    out_blk_next   = ram_rdata;
                    out_hit_next   = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = ST_RETAG;
                end
            end

            ST_RETAG:
            begin
                // retag the victim with clean marks and send it to the tail
                ram_cmd.wr           = 1'b1;
                valid_next[slot_reg] = 1'b1;
                done_next[slot_reg]  = 1'b0;
                dly_next[slot_reg]   = 1'b0;
                mtt                  = 1'b1;
                mtt_pos              = '0;
                state_next           = ST_GRANT;
            end

            ST_GRANT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_GRANT;
                    out_slot_next  = slot_reg;
                    out_blk_next   = blk_reg;
                    out_hit_next   = hit_reg;
                    out_last_next  = 1'b0;
                    case (kind_reg)
                        REQ_DWRITE:
                        begin
                            dly_next[slot_reg]  = 1'b1;
                            done_next[slot_reg] = 1'b1;
                            out_last_next       = 1'b1;
                            state_next          = ST_IDLE;
                        end
                        REQ_WTHRU:
                        begin
                            dly_next[slot_reg]  = 1'b0;
                            done_next[slot_reg] = 1'b0;
                            state_next          = ST_WTHRU;
                        end
                        default:
                        begin
                            if (done_reg[slot_reg])
                            begin
                                out_last_next = 1'b1;
                                state_next    = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_FILL;
                            end
                        end
                    endcase
                end
            end

            ST_FILL, ST_WTHRU:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = (state_reg == ST_FILL) ? ACT_FILL : ACT_WRITE;
                    out_slot_next  = slot_reg;
                    out_blk_next   = blk_reg;
                    out_hit_next   = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_FL_CHK:
            begin
                // pos tracks the next unvisited slot: moved slots leave it in place
                if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    state_next = ST_FL_DONE;
                end
                else
                begin
                    slot_next = queue_reg[pos_reg];
                    if (dly_reg[queue_reg[pos_reg]])
                    begin
                        ram_cmd.rd = 1'b1;
                        ram_addr   = queue_reg[pos_reg];
                        state_next = ST_FL_EMIT;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            ST_FL_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next      = 1'b1;
                    out_act_next        = ACT_WRITE;
                    out_slot_next       = slot_reg;
                    out_blk_next        = ram_rdata;
                    out_hit_next        = 1'b0;
                    out_last_next       = 1'b0;
                    dly_next[slot_reg]  = 1'b0;
                    done_next[slot_reg] = 1'b0;
                    mtt                 = 1'b1;
                    mtt_pos             = pos_reg;
                    cnt_next            = cnt_reg + 1'b1;
                    state_next          = ST_FL_CHK;
                end
            end

            ST_FL_DONE:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_DONE;
                    out_slot_next  = '0;
                    out_blk_next   = '0;
                    out_hit_next   = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Queue rotation: drop the entry at mtt_pos, close the gap, append it.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            queue_next[i] = queue_reg[i];
            if (mtt && (i >= int'(mtt_pos)) && (i < NUM_SLOTS - 1))
            begin
                queue_next[i] = queue_reg[i + 1];
            end
        end
        if (mtt)
        begin
            queue_next[NUM_SLOTS - 1] = queue_reg[mtt_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            done_reg      <= '0;
            dly_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                queue_reg[i] <= SW'(NUM_SLOTS - 1 - i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
            dly_reg       <= dly_next;
            out_valid_reg <= out_valid_next;
            queue_reg     <= queue_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        blk_reg      <= blk_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        out_act_reg  <= out_act_next;
        out_slot_reg <= out_slot_next;
        out_blk_reg  <= out_blk_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, BLK_IN_W'(out_blk_reg), SLOT_OUT_W'(out_slot_reg)};
    assign m_axis_tuser  = {out_hit_reg, out_act_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: src/bbct_checker.sv
// ----------------------------------------------------------------------------
// Block buffer cache tags: port checker
// Watches the top-level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_tags_core_macros.svh"

module bbct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import bbct_pkg::*;

    logic out_stall;
    logic req_taken;
    logic is_done;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign req_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser <= REQ_PROBE);
    assign is_done   = m_axis_tvalid && (m_axis_tuser[1:0] == ACT_DONE);

    // hold a stalled result
    `BBCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    // a taken request blocks the next one until it finishes
    `BBCT_ASSERT_NEXT(a_busy, clk, rst_n, req_taken, !s_axis_tready, "request taken while busy")
    // flush completion is the last result and carries no slot or block
    `BBCT_ASSERT(a_done_fields, clk, rst_n, !is_done || (m_axis_tlast && m_axis_tdata == 32'd0 && !m_axis_tuser[2]), "bad flush completion")
    // hit only on grant or probe results
    `BBCT_ASSERT(a_hit_grant, clk, rst_n, !m_axis_tvalid || !m_axis_tuser[2] || (m_axis_tuser[1:0] == ACT_GRANT), "hit on non-grant result")

endmodule

bind block_buffer_cache_tags_core bbct_checker u_bbct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
